// File: hdl/bvs_pkg.sv
// Shared types and constants for the bencode value end scanner.
package bvs_pkg;

  // Deepest container nesting accepted before flagging overflow.
  localparam int MAX_DEPTH   = 64;
  // Widest string length field; longer lengths are flagged as errors.
  localparam int LENGTH_BITS = 32;
  // Nesting depth counter width, enough to hold MAX_DEPTH itself.
  localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
  // Width of the saturating byte count.
  localparam int COUNT_W     = 32;

  localparam logic [7:0] CH_DICT  = 8'h64;  // 'd'
  localparam logic [7:0] CH_LIST  = 8'h6C;  // 'l'
  localparam logic [7:0] CH_INT   = 8'h69;  // 'i'
  localparam logic [7:0] CH_END   = 8'h65;  // 'e'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    ST_SCAN  = 2'd0,
    ST_DONE  = 2'd1,
    ST_BAD   = 2'd2,
    ST_TRUNC = 2'd3
  } bvs_status_t;

endpackage

// File: hdl/bvs_if.sv
// Valid/ready channel interfaces for the byte input and the status output.
interface bvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface bvs_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  scan_status;
  logic [bvs_pkg::COUNT_W-1:0] bytes_consumed;

  modport source (output valid, output scan_status, output bytes_consumed, input ready);
  modport sink   (input valid, input scan_status, input bytes_consumed, output ready);
endinterface

// File: hdl/bencode_value_end_scanner.sv
// Top level of the bencode value end scanner: parser state, output register and skid stage.
//
// The scanner takes one byte of a bencoded stream per request on in_ch and
// returns one status request per byte on out_ch: 0 scanning, 1 the first
// complete top-level value ends on this byte, 2 bad character, unmatched 'e',
// nesting deeper than MAX_DEPTH or a string length wider than LENGTH_BITS,
// 3 the byte flagged last_byte left the value unfinished. bytes_consumed is
// the saturating count of bytes of the current value including this one.
// Any status other than 0 returns the scanner to idle, so the next byte
// starts a new value counted from 1. Throughput is one byte per cycle while
// in_ch.ready is high. The parser state update (a times-ten length
// accumulate, a depth step and a counter increment) sits between the input
// handshake and the output register. A two-deep output (register plus skid
// stage) keeps accepting while a result waits; in_ch.ready drops only when
// both are full. No clearing pass follows reset.
module bencode_value_end_scanner (
  input  logic            clk,
  input  logic            rst_n,
  bvs_in_if.sink          in_ch,
  bvs_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    MODE_VALUE,   // expecting a value or a closing 'e'
    MODE_INT,     // inside an integer, waiting for 'e'
    MODE_LEN,     // reading string length digits
    MODE_SKIP     // skipping string body bytes
  } mode_t;

  localparam int ACC_W = bvs_pkg::LENGTH_BITS + 4;

  // Parser state
  mode_t                           mode_r, mode_nxt;
  logic [bvs_pkg::DEPTH_W-1:0]     depth_r, depth_nxt;
  logic [bvs_pkg::LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic [bvs_pkg::COUNT_W-1:0]     count_r, count_nxt;

  // Output register and skid stage
  logic                        out_valid_r;
  bvs_pkg::bvs_status_t        out_status_r;
  logic [bvs_pkg::COUNT_W-1:0] out_count_r;
  logic                        skid_valid_r;
  bvs_pkg::bvs_status_t        skid_status_r;
  logic [bvs_pkg::COUNT_W-1:0] skid_count_r;

  logic                        accept;
  logic                        out_free;
  logic                        is_digit;
  logic [3:0]                  digit;
  logic [ACC_W-1:0]            len_acc;
  logic                        len_ovf;
  logic [bvs_pkg::COUNT_W-1:0] count_inc;
  bvs_pkg::bvs_status_t        status;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign is_digit = (in_ch.byte_value >= bvs_pkg::CH_ZERO) &&
                    (in_ch.byte_value <= bvs_pkg::CH_NINE);
  assign digit    = 4'(in_ch.byte_value - bvs_pkg::CH_ZERO);

  // remain * 10 + digit as shift-and-add; any bit above the length field is overflow
  assign len_acc = ACC_W'({remain_r, 3'b000}) + ACC_W'({remain_r, 1'b0}) +
                   ACC_W'(digit);
  assign len_ovf = |len_acc[ACC_W-1:bvs_pkg::LENGTH_BITS];

  assign count_inc = (&count_r) ? count_r : count_r + bvs_pkg::COUNT_W'(1);

  always_comb begin
    mode_nxt   = mode_r;
    depth_nxt  = depth_r;
    remain_nxt = remain_r;
    status     = bvs_pkg::ST_SCAN;
    case (mode_r)
      MODE_VALUE: begin
        if (in_ch.byte_value == bvs_pkg::CH_DICT ||
            in_ch.byte_value == bvs_pkg::CH_LIST) begin
          if (depth_r >= bvs_pkg::DEPTH_W'(bvs_pkg::MAX_DEPTH)) begin
            status = bvs_pkg::ST_BAD;
          end else begin
            depth_nxt = depth_r + bvs_pkg::DEPTH_W'(1);
          end
        end else if (in_ch.byte_value == bvs_pkg::CH_END) begin
          if (depth_r == '0) begin
            status = bvs_pkg::ST_BAD;   // unmatched close
          end else begin
            depth_nxt = depth_r - bvs_pkg::DEPTH_W'(1);
            if (depth_r == bvs_pkg::DEPTH_W'(1)) status = bvs_pkg::ST_DONE;
          end
        end else if (in_ch.byte_value == bvs_pkg::CH_INT) begin
          mode_nxt = MODE_INT;
        end else if (is_digit) begin
          remain_nxt = bvs_pkg::LENGTH_BITS'(digit);
          mode_nxt   = MODE_LEN;
        end else begin
          status = bvs_pkg::ST_BAD;
        end
      end
      MODE_INT: begin
        if (in_ch.byte_value == bvs_pkg::CH_END) begin
          if (depth_r == '0) status = bvs_pkg::ST_DONE;
          else               mode_nxt = MODE_VALUE;
        end
      end
      MODE_LEN: begin
        if (is_digit) begin
          if (len_ovf) status = bvs_pkg::ST_BAD;
          else         remain_nxt = len_acc[bvs_pkg::LENGTH_BITS-1:0];
        end else if (remain_r == '0) begin
          // empty string ends on its colon
          if (depth_r == '0) status = bvs_pkg::ST_DONE;
          else               mode_nxt = MODE_VALUE;
        end else begin
          mode_nxt = MODE_SKIP;   // colon taken unchecked
        end
      end
      MODE_SKIP: begin
        remain_nxt = remain_r - bvs_pkg::LENGTH_BITS'(1);
        if (remain_r == bvs_pkg::LENGTH_BITS'(1)) begin
          if (depth_r == '0) status = bvs_pkg::ST_DONE;
          else               mode_nxt = MODE_VALUE;
        end
      end
      default: status = bvs_pkg::ST_BAD;
    endcase

    if (status == bvs_pkg::ST_SCAN && in_ch.last_byte) status = bvs_pkg::ST_TRUNC;

    count_nxt = count_inc;
    if (status != bvs_pkg::ST_SCAN) begin
      // value finished one way or another: back to idle
      mode_nxt   = MODE_VALUE;
      depth_nxt  = '0;
      remain_nxt = '0;
      count_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_VALUE;
      depth_r      <= '0;
      remain_r     <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r   <= mode_nxt;
        depth_r  <= depth_nxt;
        remain_r <= remain_nxt;
        count_r  <= count_nxt;
      end
      if (out_free) begin
        if (skid_valid_r) begin
          // drain skid first; input is held off while it is full
          out_valid_r  <= 1'b1;
          out_status_r <= skid_status_r;
          out_count_r  <= skid_count_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= accept;
          if (accept) begin
            out_status_r <= status;
            out_count_r  <= count_inc;
          end
        end
      end else if (accept) begin
        skid_valid_r  <= 1'b1;
        skid_status_r <= status;
        skid_count_r  <= count_inc;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.scan_status    = out_status_r;
  assign out_ch.bytes_consumed = out_count_r;

endmodule

// File: hdl/bvs_checker.sv
// Port-level assertions for the bencode value end scanner, bound to the top level.
module bvs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_scan_status,
  input logic [bvs_pkg::COUNT_W-1:0] out_bytes_consumed
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scan_status) &&
                                $stable(out_bytes_consumed))
    else $error("result changed while stalled");

  // Nothing comes out right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A request taken while the output stalls fills the skid stage.
  a_skid_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_valid && !out_ready |=> !in_ready)
    else $error("skid stage did not block input");

  // A last byte never reports scanning.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_byte && (!out_valid || out_ready) |=>
      out_valid && out_scan_status != bvs_pkg::ST_SCAN)
    else $error("last byte reported as scanning");

  // Every result counts at least its own byte.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_consumed != '0)
    else $error("zero byte count on result");

endmodule

bind bencode_value_end_scanner bvs_checker u_bvs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .in_last_byte       (in_ch.last_byte),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_scan_status    (out_ch.scan_status),
  .out_bytes_consumed (out_ch.bytes_consumed)
);
